// ===== src/grid_bin_index_top_defines.svh =====
// ----------------------------------------------------------------------------
// Grid bin index: assertion macros
// Shared concurrent assertion forms, clocked on aclk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef GRID_BIN_INDEX_TOP_DEFINES_SVH
`define GRID_BIN_INDEX_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GBI_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("grid bin index check failed");

// The consequent must hold in the cycle after the antecedent.
`define GBI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("grid bin index check failed");

`endif

// ===== src/gbi_pkg.sv =====
// ----------------------------------------------------------------------------
// Grid bin index package
// Widths, codes, register map and shared types of the grid binning pipeline.
// ----------------------------------------------------------------------------
package gbi_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int MAX_CELLS  = 256;

    localparam int POS_W      = 32;
    localparam int HALF_W     = 31;
    localparam int D_W        = POS_W + 1;
    localparam int V_W        = POS_W + 2;
    localparam int INV_W      = 32;
    localparam int IDX_W      = 32;
    localparam int PROD_W     = V_W + INV_W;
    localparam int QSHIFT     = 2 * FRAC_BITS;
    localparam int CELL_W     = 9;
    localparam int AXIS_W     = 8;
    localparam int NTOT_W     = 2 * CELL_W - 1;
    localparam int LIN_W      = IDX_W + CELL_W + 1;
    localparam int LIM_W      = CELL_W + 1;
    localparam int EXT_SUM_W  = IDX_W + 2;

    // Stage 0 forms the offsets, stages 1 to 5 the axis indices,
    // stages 6 to 8 the clamping, the linear bin and the result register.
    localparam int IDX_STAGE  = 5;
    localparam int STAGES     = IDX_STAGE + 4;

    localparam int S_TDATA_W  = ((2 * POS_W + 2 * HALF_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((3 * IDX_W + 2 * AXIS_W + 7) / 8) * 8;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int ADDR_LSB   = 2;

    localparam logic signed [IDX_W-1:0] IDX_MAX = {1'b0, {(IDX_W-1){1'b1}}};
    localparam logic signed [IDX_W-1:0] IDX_MIN = {1'b1, {(IDX_W-1){1'b0}}};

    typedef logic [STAGES-1:0] stage_vec_t;

    typedef enum logic [1:0] {
        FUNC_RAW    = 2'd0,
        FUNC_CLAMP  = 2'd1,
        FUNC_AXIS   = 2'd2,
        FUNC_WINDOW = 2'd3
    } func_t;

    typedef enum logic [CFG_ADDR_W-ADDR_LSB-1:0] {
        REG_Y_ORIGIN = 3'd0,
        REG_Z_ORIGIN = 3'd1,
        REG_Y_INV    = 3'd2,
        REG_Z_INV    = 3'd3,
        REG_CELLS_Y  = 3'd4,
        REG_CELLS_Z  = 3'd5
    } reg_addr_t;

    typedef struct packed {
        logic signed [POS_W-1:0] y_origin;
        logic signed [POS_W-1:0] z_origin;
        logic [INV_W-1:0]        y_inv;
        logic [INV_W-1:0]        z_inv;
        logic [CELL_W-1:0]       ny;
        logic [CELL_W-1:0]       nz;
        logic [NTOT_W-1:0]       ntot;
    } cfg_t;

endpackage

// ===== src/gbi_cfg.sv =====
// ----------------------------------------------------------------------------
// Grid bin index configuration registers
// APB register file holding the grid origin, inverse steps and cell counts.
// ----------------------------------------------------------------------------
module gbi_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gbi_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [gbi_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [gbi_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,
    output gbi_pkg::cfg_t                   cfg
);
    import gbi_pkg::*;

    logic signed [POS_W-1:0] y_origin_reg;
    logic signed [POS_W-1:0] z_origin_reg;
    logic [INV_W-1:0]        y_inv_reg;
    logic [INV_W-1:0]        z_inv_reg;
    logic [CELL_W-1:0]       cells_y_reg;
    logic [CELL_W-1:0]       cells_z_reg;
    logic [NTOT_W-1:0]       ntot_reg;
    logic [NTOT_W-1:0]       ntot_next;
    logic [CELL_W-1:0]       ny;
    logic [CELL_W-1:0]       nz;
    logic                    wr;
    reg_addr_t               addr;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign addr   = reg_addr_t'(paddr[CFG_ADDR_W-1:ADDR_LSB]);

    // Counts above the grid limit behave as the limit.
    assign ny = (cells_y_reg > CELL_W'(MAX_CELLS)) ? CELL_W'(MAX_CELLS) : cells_y_reg;
    assign nz = (cells_z_reg > CELL_W'(MAX_CELLS)) ? CELL_W'(MAX_CELLS) : cells_z_reg;
    assign ntot_next = NTOT_W'(ny) * NTOT_W'(nz);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            y_origin_reg <= '0;
            z_origin_reg <= '0;
            y_inv_reg    <= INV_W'(1) << FRAC_BITS;
            z_inv_reg    <= INV_W'(1) << FRAC_BITS;
            cells_y_reg  <= CELL_W'(1);
            cells_z_reg  <= CELL_W'(1);
            ntot_reg     <= NTOT_W'(1);
        end else begin
            ntot_reg <= ntot_next;
            if (wr) begin
                unique case (addr)
                    REG_Y_ORIGIN: y_origin_reg <= $signed(pwdata[POS_W-1:0]);
                    REG_Z_ORIGIN: z_origin_reg <= $signed(pwdata[POS_W-1:0]);
                    REG_Y_INV:    y_inv_reg    <= pwdata[INV_W-1:0];
                    REG_Z_INV:    z_inv_reg    <= pwdata[INV_W-1:0];
                    REG_CELLS_Y:  cells_y_reg  <= pwdata[CELL_W-1:0];
                    REG_CELLS_Z:  cells_z_reg  <= pwdata[CELL_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        unique case (addr)
            REG_Y_ORIGIN: prdata = CFG_DATA_W'($unsigned(y_origin_reg));
            REG_Z_ORIGIN: prdata = CFG_DATA_W'($unsigned(z_origin_reg));
            REG_Y_INV:    prdata = CFG_DATA_W'(y_inv_reg);
            REG_Z_INV:    prdata = CFG_DATA_W'(z_inv_reg);
            REG_CELLS_Y:  prdata = CFG_DATA_W'(cells_y_reg);
            REG_CELLS_Z:  prdata = CFG_DATA_W'(cells_z_reg);
            default:      prdata = '0;
        endcase
    end

    assign cfg.y_origin = y_origin_reg;
    assign cfg.z_origin = z_origin_reg;
    assign cfg.y_inv    = y_inv_reg;
    assign cfg.z_inv    = z_inv_reg;
    assign cfg.ny       = ny;
    assign cfg.nz       = nz;
    assign cfg.ntot     = ntot_reg;

endmodule

// ===== src/gbi_ctrl.sv =====
// ----------------------------------------------------------------------------
// Grid bin index pipeline control
// Valid bits of every stage and the per-stage load enables; bubbles collapse.
// ----------------------------------------------------------------------------
`include "grid_bin_index_top_defines.svh"

module gbi_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output gbi_pkg::stage_vec_t en
);
    import gbi_pkg::*;

    stage_vec_t valid_reg;
    stage_vec_t valid_next;

    // A stage may load when it is empty or when its content moves on.
    always_comb begin
        en[STAGES-1] = !valid_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    always_comb begin
        valid_next[0] = en[0] ? in_valid : valid_reg[0];
        for (int k = 1; k < STAGES; k++) begin
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[STAGES-1];

    `GBI_ASSERT_NOW(a_accept_when_empty, !valid_reg[0], in_ready)
    `GBI_ASSERT_NEXT(a_result_held, valid_reg[STAGES-1] && !out_ready, valid_reg[STAGES-1])
    `GBI_ASSERT_NOW(a_full_refuses, ($countones(valid_reg) == STAGES) && !out_ready, !in_ready)

endmodule

// ===== src/gbi_axis.sv =====
// ----------------------------------------------------------------------------
// Grid bin index axis unit
// Five stages: offset, magnitude, split product, shift, sign and saturation.
// ----------------------------------------------------------------------------
module gbi_axis (
    input  logic                              aclk,
    input  gbi_pkg::stage_vec_t               en,
    input  logic signed [gbi_pkg::D_W-1:0]    d,
    input  logic [gbi_pkg::HALF_W-1:0]        half,
    input  logic                              use_half,
    input  logic                              sub_half,
    input  logic [gbi_pkg::INV_W-1:0]         inv,
    output logic signed [gbi_pkg::IDX_W-1:0]  idx
);
    import gbi_pkg::*;

    logic signed [V_W-1:0]    hx;
    logic signed [V_W-1:0]    dx;
    logic signed [V_W-1:0]    v_next;
    logic signed [V_W-1:0]    v_reg;
    logic                     neg_next;
    logic [V_W-1:0]           mag_next;
    logic                     neg2_reg;
    logic [V_W-1:0]           mag_reg;
    logic [2*INV_W-1:0]       p_lo_next;
    logic [V_W-1:0]           p_hi_next;
    logic [2*INV_W-1:0]       p_lo_reg;
    logic [V_W-1:0]           p_hi_reg;
    logic                     neg3_reg;
    logic [PROD_W-1:0]        sum;
    logic [PROD_W-1:0]        q_next;
    logic [PROD_W-1:0]        q_reg;
    logic                     neg4_reg;
    logic signed [IDX_W-1:0]  idx_next;
    logic signed [IDX_W-1:0]  idx_reg;

    // Stage 1: shift the offset by the window half width when asked.
    assign hx     = use_half ? $signed({{(V_W-HALF_W){1'b0}}, half}) : '0;
    assign dx     = $signed({d[D_W-1], d});
    assign v_next = sub_half ? (dx - hx) : (dx + hx);

    // Stage 2: sign and magnitude, so that the product truncates toward zero.
    assign neg_next = v_reg[V_W-1];
    assign mag_next = neg_next ? V_W'(-v_reg) : V_W'(v_reg);

    // Stage 3: the wide product in two parts, low word and top bits.
    assign p_lo_next = mag_reg[INV_W-1:0] * inv;
    assign p_hi_next = V_W'(mag_reg[V_W-1:INV_W]) * V_W'(inv);

    // Stage 4: recombine and drop the fraction bits of both operands.
    assign sum    = {p_hi_reg, {INV_W{1'b0}}} + {{(PROD_W-2*INV_W){1'b0}}, p_lo_reg};
    assign q_next = sum >> QSHIFT;

    // Stage 5: restore the sign and saturate to the signed index range.
    always_comb begin
        if (!neg4_reg) begin
            if (q_reg > PROD_W'($unsigned(IDX_MAX))) begin
                idx_next = IDX_MAX;
            end else begin
                idx_next = $signed(q_reg[IDX_W-1:0]);
            end
        end else begin
            if (q_reg > PROD_W'($unsigned(IDX_MIN))) begin
                idx_next = IDX_MIN;
            end else begin
                idx_next = $signed(-q_reg[IDX_W-1:0]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            v_reg <= v_next;
        end
        if (en[2]) begin
            neg2_reg <= neg_next;
            mag_reg  <= mag_next;
        end
        if (en[3]) begin
            neg3_reg <= neg2_reg;
            p_lo_reg <= p_lo_next;
            p_hi_reg <= p_hi_next;
        end
        if (en[4]) begin
            neg4_reg <= neg3_reg;
            q_reg    <= q_next;
        end
        if (en[5]) begin
            idx_reg <= idx_next;
        end
    end

    assign idx = idx_reg;

endmodule

// ===== src/gbi_post.sv =====
// ----------------------------------------------------------------------------
// Grid bin index result stages
// Axis clamping, window extents, linear bin and the per-mode result register.
// ----------------------------------------------------------------------------
module gbi_post (
    input  logic                              aclk,
    input  gbi_pkg::stage_vec_t               en,
    input  gbi_pkg::func_t                    func,
    input  gbi_pkg::cfg_t                     cfg,
    input  logic signed [gbi_pkg::IDX_W-1:0]  ya,
    input  logic signed [gbi_pkg::IDX_W-1:0]  yb,
    input  logic signed [gbi_pkg::IDX_W-1:0]  za,
    input  logic signed [gbi_pkg::IDX_W-1:0]  zb,
    output logic signed [gbi_pkg::IDX_W-1:0]  bin,
    output logic [gbi_pkg::AXIS_W-1:0]        bin_y,
    output logic [gbi_pkg::AXIS_W-1:0]        bin_z,
    output logic signed [gbi_pkg::IDX_W-1:0]  extent_y,
    output logic signed [gbi_pkg::IDX_W-1:0]  extent_z,
    output logic                              out_of_range
);
    import gbi_pkg::*;

    localparam int S6 = IDX_STAGE + 1;
    localparam int S7 = IDX_STAGE + 2;
    localparam int S8 = IDX_STAGE + 3;

    function automatic logic [AXIS_W-1:0] clamp_axis(
        input logic signed [IDX_W-1:0] v,
        input logic [CELL_W-1:0]       n
    );
        logic signed [IDX_W-1:0] n_s;
        logic [CELL_W-1:0]       top;
        logic [AXIS_W-1:0]       r;
        n_s = $signed({{(IDX_W-CELL_W){1'b0}}, n});
        top = n - 1'b1;
        if (n == '0 || v < 0) begin
            r = '0;
        end else if (v >= n_s) begin
            r = top[AXIS_W-1:0];
        end else begin
            r = v[AXIS_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [IDX_W-1:0] diff_sat(
        input logic signed [IDX_W-1:0] hi,
        input logic signed [IDX_W-1:0] lo
    );
        logic signed [IDX_W:0] diff;
        logic signed [IDX_W-1:0] r;
        diff = $signed({hi[IDX_W-1], hi}) - $signed({lo[IDX_W-1], lo});
        if (diff[IDX_W] != diff[IDX_W-1]) begin
            r = diff[IDX_W] ? IDX_MIN : IDX_MAX;
        end else begin
            r = diff[IDX_W-1:0];
        end
        return r;
    endfunction

    // The window may not run past the last cell of the axis.
    function automatic logic signed [IDX_W-1:0] fit_extent(
        input logic signed [IDX_W-1:0] e,
        input logic [AXIS_W-1:0]       c,
        input logic [CELL_W-1:0]       n
    );
        logic signed [EXT_SUM_W-1:0] reach;
        logic signed [LIM_W-1:0]     lim;
        logic signed [IDX_W-1:0]     r;
        reach = $signed({{(EXT_SUM_W-IDX_W){e[IDX_W-1]}}, e})
              + $signed({{(EXT_SUM_W-AXIS_W){1'b0}}, c});
        lim   = $signed({1'b0, n}) - LIM_W'(1) - $signed({{(LIM_W-AXIS_W){1'b0}}, c});
        if (reach >= $signed({{(EXT_SUM_W-CELL_W){1'b0}}, n})) begin
            r = {{(IDX_W-LIM_W){lim[LIM_W-1]}}, lim};
        end else begin
            r = e;
        end
        return r;
    endfunction

    // Stage 6 signals.
    logic [AXIS_W-1:0]        yc_next;
    logic [AXIS_W-1:0]        zc_next;
    logic signed [IDX_W-1:0]  mz_next;
    logic signed [IDX_W-1:0]  my_next;
    logic                     linear_mode;
    func_t                    func6_reg;
    logic [AXIS_W-1:0]        yc6_reg;
    logic [AXIS_W-1:0]        zc6_reg;
    logic signed [IDX_W-1:0]  mz_reg;
    logic signed [IDX_W-1:0]  my_reg;
    logic signed [IDX_W-1:0]  eyr_reg;
    logic signed [IDX_W-1:0]  ezr_reg;

    // Stage 7 signals.
    logic signed [LIN_W-1:0]  prod;
    logic signed [LIN_W-1:0]  lin_next;
    func_t                    func7_reg;
    logic [AXIS_W-1:0]        yc7_reg;
    logic [AXIS_W-1:0]        zc7_reg;
    logic signed [LIN_W-1:0]  lin_reg;
    logic signed [IDX_W-1:0]  ey7_reg;
    logic signed [IDX_W-1:0]  ez7_reg;

    // Stage 8 signals.
    logic signed [LIN_W-1:0]  ntot_s;
    logic signed [LIN_W-1:0]  lin_clamp;
    logic signed [IDX_W-1:0]  lin_sat;
    logic                     lin_fits;
    logic                     lin_outside;
    logic signed [IDX_W-1:0]  bin_next;
    logic [AXIS_W-1:0]        bin_y_next;
    logic [AXIS_W-1:0]        bin_z_next;
    logic signed [IDX_W-1:0]  extent_y_next;
    logic signed [IDX_W-1:0]  extent_z_next;
    logic                     oor_next;
    logic signed [IDX_W-1:0]  bin_reg;
    logic [AXIS_W-1:0]        bin_y_reg;
    logic [AXIS_W-1:0]        bin_z_reg;
    logic signed [IDX_W-1:0]  extent_y_reg;
    logic signed [IDX_W-1:0]  extent_z_reg;
    logic                     oor_reg;

    // Stage 6: in raw and clamp modes the lower index is the plain axis index.
    assign linear_mode = (func == FUNC_RAW) || (func == FUNC_CLAMP);
    assign yc_next     = clamp_axis(ya, cfg.ny);
    assign zc_next     = clamp_axis(za, cfg.nz);
    assign mz_next     = linear_mode ? za : $signed({{(IDX_W-AXIS_W){1'b0}}, zc_next});
    assign my_next     = linear_mode ? ya : $signed({{(IDX_W-AXIS_W){1'b0}}, yc_next});

    // Stage 7: linear bin z * ny + y, exact.
    assign prod     = mz_reg * $signed({1'b0, cfg.ny});
    assign lin_next = prod + $signed({{(LIN_W-IDX_W){my_reg[IDX_W-1]}}, my_reg});

    // Stage 8: range flag, saturation and clamping of the linear bin.
    assign ntot_s      = $signed({{(LIN_W-NTOT_W){1'b0}}, cfg.ntot});
    assign lin_outside = lin_reg[LIN_W-1] || (lin_reg >= ntot_s);
    assign lin_fits    = (&lin_reg[LIN_W-1:IDX_W-1]) || !(|lin_reg[LIN_W-1:IDX_W-1]);

    always_comb begin
        if (lin_fits) begin
            lin_sat = lin_reg[IDX_W-1:0];
        end else begin
            lin_sat = lin_reg[LIN_W-1] ? IDX_MIN : IDX_MAX;
        end
        lin_clamp = (lin_reg >= ntot_s) ? (ntot_s - LIN_W'(1)) : lin_reg;
        if (lin_clamp[LIN_W-1]) begin
            lin_clamp = '0;
        end
    end

    always_comb begin
        bin_next      = '0;
        bin_y_next    = '0;
        bin_z_next    = '0;
        extent_y_next = '0;
        extent_z_next = '0;
        oor_next      = 1'b0;
        unique case (func7_reg)
            FUNC_RAW: begin
                bin_next = lin_sat;
                oor_next = lin_outside;
            end
            FUNC_CLAMP: begin
                bin_next = lin_clamp[IDX_W-1:0];
            end
            FUNC_AXIS: begin
                bin_next   = lin_reg[IDX_W-1:0];
                bin_y_next = yc7_reg;
                bin_z_next = zc7_reg;
            end
            FUNC_WINDOW: begin
                bin_next      = lin_reg[IDX_W-1:0];
                bin_y_next    = yc7_reg;
                bin_z_next    = zc7_reg;
                extent_y_next = ey7_reg;
                extent_z_next = ez7_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en[S6]) begin
            func6_reg <= func;
            yc6_reg   <= yc_next;
            zc6_reg   <= zc_next;
            mz_reg    <= mz_next;
            my_reg    <= my_next;
            eyr_reg   <= diff_sat(yb, ya);
            ezr_reg   <= diff_sat(zb, za);
        end
        if (en[S7]) begin
            func7_reg <= func6_reg;
            yc7_reg   <= yc6_reg;
            zc7_reg   <= zc6_reg;
            lin_reg   <= lin_next;
            ey7_reg   <= fit_extent(eyr_reg, yc6_reg, cfg.ny);
            ez7_reg   <= fit_extent(ezr_reg, zc6_reg, cfg.nz);
        end
        if (en[S8]) begin
            bin_reg      <= bin_next;
            bin_y_reg    <= bin_y_next;
            bin_z_reg    <= bin_z_next;
            extent_y_reg <= extent_y_next;
            extent_z_reg <= extent_z_next;
            oor_reg      <= oor_next;
        end
    end

    assign bin          = bin_reg;
    assign bin_y        = bin_y_reg;
    assign bin_z        = bin_z_reg;
    assign extent_y     = extent_y_reg;
    assign extent_z     = extent_z_reg;
    assign out_of_range = oor_reg;

endmodule

// ===== src/grid_bin_index_top.sv =====
// ----------------------------------------------------------------------------
// Grid bin index
// Maps 2D fixed-point points to cells of a uniform grid in four modes.
// ----------------------------------------------------------------------------
// Usage:
//   Points enter on the s_ stream: s_tuser carries the mode, s_tdata the
//   coordinates and window half widths. Each request gives exactly one result
//   on the m_ stream: m_tdata carries the bin, the clamped axis cells and the
//   window extents, m_tuser the out-of-range flag of the raw mode.
//   Grid origin, inverse steps and cell counts must be set over the APB port
//   while no request is in flight; the block itself does not enforce this.
//   Reset loads origin 0, step 1.0, one cell. The datapath has nine register
//   stages, and one request may enter per cycle unless the receiver stalls
//   and every stage is full. The depth is set by the 34 x 32 bit index
//   product, which is split over a multiply stage and a recombine stage, and
//   by the linear bin multiply that follows the clamping.
//   When the receiver stalls, stages with a result hold it and empty stages
//   behind them keep filling, so s_tready drops only once every stage holds
//   a request. Reset empties the pipeline; results in flight are dropped.
// ----------------------------------------------------------------------------
module grid_bin_index_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // pos_y[31:0], pos_z[63:32], half_y[94:64], half_z[125:95], zero fill
    input  logic [gbi_pkg::S_TDATA_W-1:0]   s_tdata,
    // func[1:0]
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // bin[31:0], bin_y[39:32], bin_z[47:40], extent_y[79:48], extent_z[111:80]
    output logic [gbi_pkg::M_TDATA_W-1:0]   m_tdata,
    // out_of_range[0]
    output logic                            m_tuser,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [gbi_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [gbi_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [gbi_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import gbi_pkg::*;

    cfg_t                     cfg;
    stage_vec_t               en;
    func_t                    func_pipe_reg [0:IDX_STAGE];
    logic signed [POS_W-1:0]  pos_y;
    logic signed [POS_W-1:0]  pos_z;
    logic [HALF_W-1:0]        half_y;
    logic [HALF_W-1:0]        half_z;
    logic signed [D_W-1:0]    dy_next;
    logic signed [D_W-1:0]    dz_next;
    logic signed [D_W-1:0]    dy_reg;
    logic signed [D_W-1:0]    dz_reg;
    logic [HALF_W-1:0]        hy_reg;
    logic [HALF_W-1:0]        hz_reg;
    logic                     use_half;
    logic signed [IDX_W-1:0]  ya;
    logic signed [IDX_W-1:0]  yb;
    logic signed [IDX_W-1:0]  za;
    logic signed [IDX_W-1:0]  zb;
    logic signed [IDX_W-1:0]  bin;
    logic [AXIS_W-1:0]        bin_y;
    logic [AXIS_W-1:0]        bin_z;
    logic signed [IDX_W-1:0]  extent_y;
    logic signed [IDX_W-1:0]  extent_z;
    logic                     out_of_range;

    gbi_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gbi_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .en        (en)
    );

    assign pos_y  = $signed(s_tdata[POS_W-1:0]);
    assign pos_z  = $signed(s_tdata[2*POS_W-1:POS_W]);
    assign half_y = s_tdata[2*POS_W+HALF_W-1:2*POS_W];
    assign half_z = s_tdata[2*POS_W+2*HALF_W-1:2*POS_W+HALF_W];

    // Stage 0: offsets from the grid origin, one bit wider than the inputs.
    assign dy_next = $signed({pos_y[POS_W-1], pos_y})
                   - $signed({cfg.y_origin[POS_W-1], cfg.y_origin});
    assign dz_next = $signed({pos_z[POS_W-1], pos_z})
                   - $signed({cfg.z_origin[POS_W-1], cfg.z_origin});

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            func_pipe_reg[0] <= func_t'(s_tuser);
            dy_reg           <= dy_next;
            dz_reg           <= dz_next;
            hy_reg           <= half_y;
            hz_reg           <= half_z;
        end
        for (int k = 1; k <= IDX_STAGE; k++) begin
            if (en[k]) begin
                func_pipe_reg[k] <= func_pipe_reg[k-1];
            end
        end
    end

    assign use_half = (func_pipe_reg[0] == FUNC_WINDOW);

    gbi_axis u_axis_y_lo (
        .aclk     (aclk),
        .en       (en),
        .d        (dy_reg),
        .half     (hy_reg),
        .use_half (use_half),
        .sub_half (1'b1),
        .inv      (cfg.y_inv),
        .idx      (ya)
    );

    gbi_axis u_axis_y_hi (
        .aclk     (aclk),
        .en       (en),
        .d        (dy_reg),
        .half     (hy_reg),
        .use_half (use_half),
        .sub_half (1'b0),
        .inv      (cfg.y_inv),
        .idx      (yb)
    );

    gbi_axis u_axis_z_lo (
        .aclk     (aclk),
        .en       (en),
        .d        (dz_reg),
        .half     (hz_reg),
        .use_half (use_half),
        .sub_half (1'b1),
        .inv      (cfg.z_inv),
        .idx      (za)
    );

    gbi_axis u_axis_z_hi (
        .aclk     (aclk),
        .en       (en),
        .d        (dz_reg),
        .half     (hz_reg),
        .use_half (use_half),
        .sub_half (1'b0),
        .inv      (cfg.z_inv),
        .idx      (zb)
    );

    gbi_post u_post (
        .aclk         (aclk),
        .en           (en),
        .func         (func_pipe_reg[IDX_STAGE]),
        .cfg          (cfg),
        .ya           (ya),
        .yb           (yb),
        .za           (za),
        .zb           (zb),
        .bin          (bin),
        .bin_y        (bin_y),
        .bin_z        (bin_z),
        .extent_y     (extent_y),
        .extent_z     (extent_z),
        .out_of_range (out_of_range)
    );

    assign m_tdata = {extent_z, extent_y, bin_z, bin_y, bin};
    assign m_tuser = out_of_range;

endmodule
